[rtl/dcf_pkg.sv]
// dcf_pkg: shared types and codes for the duplicate-rejecting circular FIFO.
// No dependencies; imported by the interfaces, cell, top level and checker.
package dcf_pkg;

   localparam int WORD_W = 32;

   // request action codes
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [2:0] {
      ST_PUSHED = 3'd0,
      ST_FULL   = 3'd1,
      ST_DUP    = 3'd2,
      ST_POPPED = 3'd3,
      ST_UNDER  = 3'd4
   } status_type;

   typedef logic signed [WORD_W-1:0] word_type;

   // per-cell control from the top level
   typedef struct packed {
      logic shift;   // take the neighbor's word (pop)
      logic load;    // take the pushed word
      logic occupied;
   } cell_ctrl_type;

endpackage

[rtl/dcf_if.sv]
// dcf_req_if / dcf_rsp_if: valid/ready channels for request and response.
// Depends on dcf_pkg for the word type.
interface dcf_req_if import dcf_pkg::*;;
   logic     valid;
   logic     ready;
   logic     action;
   word_type value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface dcf_rsp_if import dcf_pkg::*; #(
   parameter int DEPTH = 8
);
   localparam int OCC_W = $clog2(DEPTH + 1);

   logic             valid;
   logic             ready;
   logic [2:0]       status;
   word_type         popped_word;
   logic [OCC_W-1:0] occupancy;
   word_type         newest_word;
   logic             newest_valid;

   modport source (output valid, output status, output popped_word, output occupancy,
                   output newest_word, output newest_valid, input ready);
   modport sink   (input valid, input status, input popped_word, input occupancy,
                   input newest_word, input newest_valid, output ready);
endinterface

[rtl/dcf_cell.sv]
// dcf_cell: one storage cell of the shifting FIFO chain with its own compare.
// Depends on dcf_pkg.
module dcf_cell import dcf_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  word_type      neighbor_word, // word of the next-younger cell
   input  word_type      push_word,
   output word_type      word,
   output logic          match
);

   word_type word_ff;
   word_type word_in;

   always_comb begin
      priority if (ctrl.shift) begin
         word_in = neighbor_word;
      end else if (ctrl.load) begin
         word_in = push_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = ctrl.occupied && (word_ff == push_word);

endmodule

[rtl/dedup_circular_fifo.sv]
// dedup_circular_fifo: top level, a chain of dcf_cell storage cells plus
// count, status logic and the response register. Depends on dcf_pkg, dcf_if.
// Usage:
//   req_chan carries one transaction per operation: action (push or pop)
//   and value (the word to push, ignored on pop). rsp_chan returns exactly
//   one transaction per request: status, popped_word, occupancy after the
//   operation, and the newest stored word with its valid flag.
//   Storage is a row of DEPTH cells; cell 0 holds the oldest word. A push
//   loads the cell at the current occupancy, a pop shifts every cell one
//   place toward cell 0. Every cell compares its word against the incoming
//   value, so all cells are checked for a duplicate at once. A full queue rejects a
//   push before any duplicate check.
// Timing:
//   Responses appear in the cycle after acceptance. Throughput is one
//   transaction per cycle while rsp_chan.ready is high (single response register).
// Reset:
//   Synchronous, active high. Occupancy goes to zero and the response
//   register empties; cell contents are not cleared and are never shown.
// Backpressure:
//   While a response waits unaccepted, req_chan.ready follows rsp_chan.ready.
module dedup_circular_fifo import dcf_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic   clock,
   input  logic   reset,
   dcf_req_if.sink   req_chan,
   dcf_rsp_if.source rsp_chan
);

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         status_ff;
   word_type           popped_ff;
   logic [COUNT_W-1:0] occ_ff;
   word_type           newest_ff;
   logic               newest_valid_ff;

   word_type           cell_word [DEPTH];
   logic [DEPTH-1:0]   cell_match;
   cell_ctrl_type      cell_ctrl [DEPTH];

   logic               accept;
   logic               is_push;
   logic               is_full;
   logic               is_empty;
   logic               is_dup;
   logic               push_ok;
   logic               pop_ok;
   status_type         status_in;
   word_type           popped_in;
   word_type           newest_in;
   word_type           last_word;
   logic [IDX_W-1:0]   last_idx;

   // a new transaction enters whenever the response slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_push  = (req_chan.action == ACT_PUSH);
   assign is_full  = (count_ff == COUNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign is_dup   = |cell_match;
   assign push_ok  = accept && is_push && !is_full && !is_dup;
   assign pop_ok   = accept && !is_push && !is_empty;

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type nbr;
      if (i == DEPTH - 1) begin : g_end
         assign nbr = cell_word[i];
      end else begin : g_mid
         assign nbr = cell_word[i+1];
      end

      assign cell_ctrl[i].shift    = pop_ok;
      assign cell_ctrl[i].load     = push_ok && (count_ff == COUNT_W'(i));
      assign cell_ctrl[i].occupied = (COUNT_W'(i) < count_ff);

      dcf_cell u_cell (
         .clock         (clock),
         .ctrl          (cell_ctrl[i]),
         .neighbor_word (nbr),
         .push_word     (req_chan.value),
         .word          (cell_word[i]),
         .match         (cell_match[i])
      );
   end

   // newest stored word before the operation sits at occupancy - 1
   assign last_idx  = IDX_W'(count_ff - 1'b1);
   assign last_word = cell_word[last_idx];

   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      priority if (is_push && is_full) begin
         status_in = ST_FULL;
      end else if (is_push && is_dup) begin
         status_in = ST_DUP;
      end else if (is_push) begin
         status_in = ST_PUSHED;
         count_in  = count_ff + 1'b1;
      end else if (is_empty) begin
         status_in = ST_UNDER;
      end else begin
         status_in = ST_POPPED;
         popped_in = cell_word[0];
         count_in  = count_ff - 1'b1;
      end

      // after a pop the old newest word is still the newest unless emptied
      if (push_ok) begin
         newest_in = req_chan.value;
      end else if (count_in != '0) begin
         newest_in = last_word;
      end else begin
         newest_in = '0;
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff       <= status_in;
         popped_ff       <= popped_in;
         occ_ff          <= count_in;
         newest_ff       <= newest_in;
         newest_valid_ff <= (count_in != '0);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.popped_word  = popped_ff;
   assign rsp_chan.occupancy    = occ_ff;
   assign rsp_chan.newest_word  = newest_ff;
   assign rsp_chan.newest_valid = newest_valid_ff;

endmodule

[rtl/dcf_checker.sv]
// dcf_checker: port-level assertions for dedup_circular_fifo, bound to it.
// Depends on dcf_pkg and on the top level's channel ports.
module dcf_checker import dcf_pkg::*; #(
   parameter int DEPTH = 8
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [2:0]                   status,
   input word_type                     popped_word,
   input logic [$clog2(DEPTH+1)-1:0]   occupancy,
   input logic                         newest_valid
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   // a stalled response keeps its valid, status and occupancy
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(occupancy))
      else $error("response changed while stalled");

   // every accepted request yields a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("missing response after request");

   a_newest_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> newest_valid == (occupancy != '0))
      else $error("newest_valid disagrees with occupancy");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_POPPED |-> popped_word == '0)
      else $error("popped word nonzero without a pop");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occupancy <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

endmodule

bind dedup_circular_fifo dcf_checker #(.DEPTH(DEPTH)) u_dcf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .popped_word  (rsp_chan.popped_word),
   .occupancy    (rsp_chan.occupancy),
   .newest_valid (rsp_chan.newest_valid)
);
